FILE: sv/csd_pkg.sv
// Shared types and constants for the capsule signed distance unit.
package csd_pkg;

    // Field widths
    localparam int PT_W   = 32;   // point, centre, distance, Hessian entries
    localparam int AX_W   = 18;   // axis and gradient components
    localparam int LEN_W  = 31;   // segment length and radius
    localparam int WM_W   = 31;   // scaled magnitude of one offset component
    localparam int SH_W   = 4;    // scale shift applied before the length
    localparam int SUM_W  = 64;   // sum of squares
    localparam int ROOT_W = 32;   // integer square root

    // Iterative unit depths
    localparam int SQ_STEPS = 32;  // one root bit per stage
    localparam int GQ_W     = 17;  // gradient quotient bits
    localparam int HQ_W     = 32;  // Hessian quotient bits
    localparam int GN_W     = 47;  // gradient numerator: magnitude shifted by 16
    localparam int HN_W     = 36;  // Hessian numerator magnitude

    // Hessian entry order: xx, xy, xz, yy, yz, zz
    localparam int HESS_N = 6;
    localparam logic [5:0][1:0] HESS_I = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [5:0][1:0] HESS_J = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

    // Configuration register indexes
    typedef enum logic [3:0] {
        CFG_CENTRE_X   = 4'd0,
        CFG_CENTRE_Y   = 4'd1,
        CFG_CENTRE_Z   = 4'd2,
        CFG_AXIS_X     = 4'd3,
        CFG_AXIS_Y     = 4'd4,
        CFG_AXIS_Z     = 4'd5,
        CFG_SEG_LENGTH = 4'd6,
        CFG_RADIUS     = 4'd7
    } t_cfg_idx;

    // Capsule geometry as held in the configuration registers
    typedef struct packed {
        logic signed [PT_W-1:0]  centre_x;
        logic signed [PT_W-1:0]  centre_y;
        logic signed [PT_W-1:0]  centre_z;
        logic signed [AX_W-1:0]  axis_x;
        logic signed [AX_W-1:0]  axis_y;
        logic signed [AX_W-1:0]  axis_z;
        logic [LEN_W-1:0]        seg_length;
        logic [LEN_W-1:0]        radius;
    } t_cfg;

    // Sideband through the square root pipeline
    typedef struct packed {
        logic [2:0][WM_W-1:0] wmag;
        logic [2:0]           wneg;
        logic [SH_W-1:0]      shift;
        logic                 line;
    } t_sq_side;

    // Sideband through the gradient divider
    typedef struct packed {
        logic [2:0]              wneg;
        logic [SH_W-1:0]         shift;
        logic                    line;
        logic signed [PT_W-1:0]  sdist;
        logic                    degen;
        logic [ROOT_W-1:0]       len;
    } t_gd_side;

    // Sideband through the Hessian divider
    typedef struct packed {
        logic [2:0][AX_W-1:0]    grad;
        logic [HESS_N-1:0]       mneg;
        logic [HESS_N-1:0]       ovf;
        logic signed [PT_W-1:0]  sdist;
        logic                    degen;
    } t_hs_side;

    localparam int GD_SIDE_W = $bits(t_gd_side);
    localparam int HS_SIDE_W = $bits(t_hs_side);

endpackage

FILE: sv/csd_front.sv
// Front pipeline: offset from centre, axis projection, segment test, scaling, sum of squares.
module csd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [31:0]         i_point_x,
    input  logic signed [31:0]         i_point_y,
    input  logic signed [31:0]         i_point_z,
    input  csd_pkg::t_cfg              i_cfg,
    output logic                       o_valid,
    output logic [csd_pkg::SUM_W-1:0]  o_sum,
    output csd_pkg::t_sq_side          o_side
);
    import csd_pkg::*;

    logic signed [PT_W-1:0] w_pt   [3];
    logic signed [PT_W-1:0] w_cen  [3];
    logic signed [AX_W-1:0] w_axis [3];
    logic [7:0]             r_vld;

    logic signed [32:0] r1_d [3];
    logic signed [32:0] r2_d [3];
    logic signed [50:0] r2_pz [3];
    logic signed [32:0] r3_d [3];
    logic signed [52:0] r3_t;
    logic signed [32:0] r4_d [3];
    logic signed [54:0] r4_pa [3];
    logic signed [49:0] r4_off [3];
    logic               r4_line;
    logic               r4_tpos;
    logic [38:0]        r5_mag [3];
    logic [2:0]         r5_neg;
    logic               r5_line;
    logic [WM_W-1:0]    r6_w [3];
    logic [2:0]         r6_neg;
    logic [SH_W-1:0]    r6_s;
    logic               r6_line;
    logic [61:0]        r7_sq [3];
    logic [WM_W-1:0]    r7_w [3];
    logic [2:0]         r7_neg;
    logic [SH_W-1:0]    r7_s;
    logic               r7_line;
    logic [SUM_W-1:0]   r8_sum;
    t_sq_side           r8_side;

    logic signed [52:0] w_half;
    logic signed [36:0] w_t16;
    logic               w_line;
    logic signed [38:0] w_sh  [3];
    logic signed [32:0] w_of  [3];
    logic signed [39:0] w_v   [3];
    logic [38:0]        w_or;
    logic [SH_W-1:0]    w_s;

    assign w_pt[0]   = i_point_x;
    assign w_pt[1]   = i_point_y;
    assign w_pt[2]   = i_point_z;
    assign w_cen[0]  = i_cfg.centre_x;
    assign w_cen[1]  = i_cfg.centre_y;
    assign w_cen[2]  = i_cfg.centre_z;
    assign w_axis[0] = i_cfg.axis_x;
    assign w_axis[1] = i_cfg.axis_y;
    assign w_axis[2] = i_cfg.axis_z;

    // Inside test against half the segment, projection floored to Q16.16
    assign w_half = $signed({7'b0, i_cfg.seg_length, 15'b0});
    assign w_line = (r3_t < w_half) && (r3_t > -w_half);
    assign w_t16  = $signed(r3_t[52:16]);

    // Offset from the axis line or from the nearer end point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i] = $signed(r4_pa[i][54:16]);
            w_of[i] = $signed(r4_off[i][49:17]);
            if (r4_line) begin
                w_v[i] = 40'(r4_d[i]) - 40'(w_sh[i]);
            end else if (r4_tpos) begin
                w_v[i] = 40'(r4_d[i]) - 40'(w_of[i]);
            end else begin
                w_v[i] = 40'(r4_d[i]) + 40'(w_of[i]);
            end
        end
    end

    // Smallest shift that brings every magnitude below 2^31
    assign w_or = r5_mag[0] | r5_mag[1] | r5_mag[2];
    always_comb begin
        w_s = '0;
        for (int b = 31; b <= 38; b++) begin
            if (w_or[b]) begin
                w_s = SH_W'(b - 30);
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // Advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i]   <= 33'(w_pt[i]) - 33'(w_cen[i]);
                r2_d[i]   <= r1_d[i];
                r2_pz[i]  <= 51'(r1_d[i]) * 51'(w_axis[i]);
                r3_d[i]   <= r2_d[i];
                r4_d[i]   <= r3_d[i];
                r4_pa[i]  <= 55'(w_t16) * 55'(w_axis[i]);
                r4_off[i] <= 50'($signed({1'b0, i_cfg.seg_length})) * 50'(w_axis[i]);
                r5_mag[i] <= w_v[i][39] ? 39'(-w_v[i]) : w_v[i][38:0];
                r5_neg[i] <= w_v[i][39];
                r6_w[i]   <= WM_W'(r5_mag[i] >> w_s);
                r7_sq[i]  <= 62'(r6_w[i]) * 62'(r6_w[i]);
                r7_w[i]   <= r6_w[i];
            end
            r3_t    <= 53'(r2_pz[0]) + 53'(r2_pz[1]) + 53'(r2_pz[2]);
            r4_line <= w_line;
            r4_tpos <= (r3_t > 53'sd0);
            r5_line <= r4_line;
            r6_neg  <= r5_neg;
            r6_s    <= w_s;
            r6_line <= r5_line;
            r7_neg  <= r6_neg;
            r7_s    <= r6_s;
            r7_line <= r6_line;
            r8_sum  <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
            r8_side.wmag  <= {r7_w[2], r7_w[1], r7_w[0]};
            r8_side.wneg  <= r7_neg;
            r8_side.shift <= r7_s;
            r8_side.line  <= r7_line;
        end
    end

    assign o_valid = r_vld[7];
    assign o_sum   = r8_sum;
    assign o_side  = r8_side;

endmodule

FILE: sv/csd_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module csd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [csd_pkg::SUM_W-1:0]   i_sum,
    input  csd_pkg::t_sq_side           i_side,
    output logic                        o_valid,
    output logic [csd_pkg::ROOT_W-1:0]  o_root,
    output csd_pkg::t_sq_side           o_side
);
    import csd_pkg::*;

    logic [33:0]        r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0]  r_root [SQ_STEPS];
    logic [SUM_W-1:0]   r_val  [SQ_STEPS];
    t_sq_side           r_side [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_vld;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic [33:0]       w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SUM_W-1:0]  w_val_in;
        t_sq_side          w_side_in;
        logic              w_vld_in;
        logic [35:0]       w_cat;
        logic [35:0]       w_trial;
        logic              w_ge;

        if (k == 0) begin : g_load
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_val_in  = i_sum;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_chain
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_val_in  = r_val[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign w_cat   = {w_rem_in, w_val_in[SUM_W-1:SUM_W-2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_ge    = (w_cat >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 34'(w_cat - w_trial) : w_cat[33:0];
                r_root[k] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_val[k]  <= {w_val_in[SUM_W-3:0], 2'b00};
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

FILE: sv/csd_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
module csd_div #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 47,
    parameter int QUO_W  = 17,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][QUO_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]             o_side
);
    logic [LANES-1:0][DEN_W-1:0] r_rem  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0] r_nq   [QUO_W];
    logic [DEN_W-1:0]            r_den  [QUO_W];
    logic [SIDE_W-1:0]           r_side [QUO_W];
    logic [QUO_W-1:0]            r_vld;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [LANES-1:0][DEN_W-1:0] w_rem_in;
        logic [LANES-1:0][QUO_W-1:0] w_nq_in;
        logic [DEN_W-1:0]            w_den_in;
        logic [SIDE_W-1:0]           w_side_in;
        logic                        w_vld_in;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0] n_nq;

        if (k == 0) begin : g_load
            // Upper numerator bits seed the remainder, lower bits shift in
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem_in[l] = DEN_W'(i_num[l] >> QUO_W);
                    w_nq_in[l]  = i_num[l][QUO_W-1:0];
                end
            end
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_chain
            assign w_rem_in  = r_rem[k-1];
            assign w_nq_in   = r_nq[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        // Shift in one bit, subtract the divisor where it fits
        always_comb begin
            logic [DEN_W:0] trial;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                trial    = {w_rem_in[l], w_nq_in[l][QUO_W-1]};
                ge       = (trial >= {1'b0, w_den_in});
                n_rem[l] = ge ? DEN_W'(trial - {1'b0, w_den_in}) : trial[DEN_W-1:0];
                n_nq[l]  = {w_nq_in[l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_nq[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

FILE: sv/capsule_signed_distance_unit.sv
// An accepted item passes through every stage to its result on the output register.
// Throughput: one item per cycle while the output is not stalled; the depth comes from
// the 32-stage square root and the 17-stage gradient and 32-stage Hessian dividers,
// each one bit per stage. A stalled output freezes the whole pipeline; an empty output
// slot lets it advance. Reset (synchronous, active low) clears all valid bits and loads
// the register reset values: centre 0, axis (0, 0, 1.0), segment length 0, radius 0.
module capsule_signed_distance_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Query items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [31:0]   i_point_z,
    // Result items
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_distance,
    output logic signed [17:0]   o_grad_x,
    output logic signed [17:0]   o_grad_y,
    output logic signed [17:0]   o_grad_z,
    output logic signed [31:0]   o_hess_xx,
    output logic signed [31:0]   o_hess_xy,
    output logic signed [31:0]   o_hess_xz,
    output logic signed [31:0]   o_hess_yy,
    output logic signed [31:0]   o_hess_yz,
    output logic signed [31:0]   o_hess_zz,
    output logic                 o_degenerate,
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import csd_pkg::*;

    t_cfg                r_cfg;
    logic                w_en;
    logic signed [AX_W-1:0] w_axis [3];

    // Front and square root
    logic                w_fr_vld;
    logic [SUM_W-1:0]    w_fr_sum;
    t_sq_side            w_fr_side;
    logic                w_sq_vld;
    logic [ROOT_W-1:0]   w_sq_root;
    t_sq_side            w_sq_side;

    // Length stage
    logic [39:0]         w_lenq;
    logic signed [40:0]  w_dd;
    logic signed [PT_W-1:0] w_dist;
    logic                rp_vld;
    logic [2:0][GN_W-1:0] rp_num;
    t_gd_side            rp_side;

    // Gradient divider
    logic                w_gd_vld;
    logic [2:0][GQ_W-1:0] w_gq;
    logic [GD_SIDE_W-1:0] w_gd_side_raw;
    t_gd_side            w_gd_side;
    logic signed [AX_W-1:0] w_n [3];

    // Product stage
    logic                rn_vld;
    logic signed [AX_W-1:0] rn_n [3];
    logic signed [35:0]  rn_nn [HESS_N];
    logic signed [35:0]  rn_zz [HESS_N];
    t_gd_side            rn_side;

    // Numerator stage
    logic signed [36:0]  w_m   [HESS_N];
    logic [HN_W-1:0]     w_mag [HESS_N];
    logic [HN_W-1:0]     w_msh [HESS_N];
    logic                rm_vld;
    logic [HESS_N-1:0][HN_W-1:0] rm_num;
    logic [ROOT_W-1:0]   rm_len;
    t_hs_side            rm_side;

    // Hessian divider
    logic                w_hd_vld;
    logic [HESS_N-1:0][HQ_W-1:0] w_hq;
    logic [HS_SIDE_W-1:0] w_hd_side_raw;
    t_hs_side            w_hd_side;
    logic signed [PT_W-1:0] w_h [HESS_N];

    // Output register
    logic                r_out_vld;
    logic signed [PT_W-1:0] r_dist;
    logic signed [AX_W-1:0] r_grad [3];
    logic signed [PT_W-1:0] r_hess [HESS_N];
    logic                r_degen;

    // Hold the whole pipeline only while a finished item waits
    assign w_en        = !(r_out_vld && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    assign w_axis[0] = r_cfg.axis_x;
    assign w_axis[1] = r_cfg.axis_y;
    assign w_axis[2] = r_cfg.axis_z;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x   <= '0;
            r_cfg.centre_y   <= '0;
            r_cfg.centre_z   <= '0;
            r_cfg.axis_x     <= '0;
            r_cfg.axis_y     <= '0;
            r_cfg.axis_z     <= 18'sd65536;
            r_cfg.seg_length <= '0;
            r_cfg.radius     <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTRE_X:   r_cfg.centre_x   <= $signed(i_cfg_data);
                CFG_CENTRE_Y:   r_cfg.centre_y   <= $signed(i_cfg_data);
                CFG_CENTRE_Z:   r_cfg.centre_z   <= $signed(i_cfg_data);
                CFG_AXIS_X:     r_cfg.axis_x     <= $signed(i_cfg_data[AX_W-1:0]);
                CFG_AXIS_Y:     r_cfg.axis_y     <= $signed(i_cfg_data[AX_W-1:0]);
                CFG_AXIS_Z:     r_cfg.axis_z     <= $signed(i_cfg_data[AX_W-1:0]);
                CFG_SEG_LENGTH: r_cfg.seg_length <= i_cfg_data[LEN_W-1:0];
                CFG_RADIUS:     r_cfg.radius     <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    csd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cfg     (r_cfg),
        .o_valid   (w_fr_vld),
        .o_sum     (w_fr_sum),
        .o_side    (w_fr_side)
    );

    csd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_vld),
        .i_sum   (w_fr_sum),
        .i_side  (w_fr_side),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Rescale the length and form the saturated distance
    assign w_lenq = 40'(w_sq_root) << w_sq_side.shift;
    assign w_dd   = $signed({1'b0, w_lenq}) - $signed({10'b0, r_cfg.radius});
    always_comb begin
        if (w_dd > 41'sd2147483647) begin
            w_dist = 32'sh7FFF_FFFF;
        end else if (w_dd < -41'sd2147483648) begin
            w_dist = 32'sh8000_0000;
        end else begin
            w_dist = w_dd[PT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
        end else if (w_en) begin
            rp_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                rp_num[i] <= {w_sq_side.wmag[i], 16'b0};
            end
            rp_side.wneg  <= w_sq_side.wneg;
            rp_side.shift <= w_sq_side.shift;
            rp_side.line  <= w_sq_side.line;
            rp_side.sdist <= w_dist;
            rp_side.degen <= (w_sq_root == '0);
            rp_side.len   <= w_sq_root;
        end
    end

    csd_div #(
        .LANES  (3),
        .NUM_W  (GN_W),
        .QUO_W  (GQ_W),
        .DEN_W  (ROOT_W),
        .SIDE_W (GD_SIDE_W)
    ) u_grad_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rp_vld),
        .i_num   (rp_num),
        .i_den   (rp_side.len),
        .i_side  (rp_side),
        .o_valid (w_gd_vld),
        .o_quo   (w_gq),
        .o_side  (w_gd_side_raw)
    );

    assign w_gd_side = w_gd_side_raw;

    // Clamp and sign the gradient components
    always_comb begin
        logic [GQ_W-1:0] qc;
        for (int i = 0; i < 3; i++) begin
            qc = (w_gq[i] > 17'd65536) ? 17'd65536 : w_gq[i];
            w_n[i] = w_gd_side.wneg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_vld <= 1'b0;
        end else if (w_en) begin
            rn_vld <= w_gd_vld;
        end
    end

    // Outer products of the gradient with itself and of the axis with itself
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                rn_n[i] <= w_n[i];
            end
            for (int k = 0; k < HESS_N; k++) begin
                rn_nn[k] <= 36'(w_n[HESS_I[k]]) * 36'(w_n[HESS_J[k]]);
                rn_zz[k] <= 36'(w_axis[HESS_I[k]]) * 36'(w_axis[HESS_J[k]]);
            end
            rn_side <= w_gd_side;
        end
    end

    // Hessian numerators, pre-shifted by the scale, with overflow check
    always_comb begin
        for (int k = 0; k < HESS_N; k++) begin
            w_m[k] = ((HESS_I[k] == HESS_J[k]) ? 37'sh1_0000_0000 : 37'sd0)
                   - (rn_side.line ? 37'(rn_zz[k]) : 37'sd0)
                   - 37'(rn_nn[k]);
            w_mag[k] = w_m[k][36] ? HN_W'(-w_m[k]) : w_m[k][HN_W-1:0];
            w_msh[k] = w_mag[k] >> rn_side.shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else if (w_en) begin
            rm_vld <= rn_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < HESS_N; k++) begin
                rm_num[k]       <= w_msh[k];
                rm_side.mneg[k] <= w_m[k][36];
                rm_side.ovf[k]  <= ({28'b0, w_msh[k][HN_W-1:HQ_W]} >= rn_side.len);
            end
            rm_side.grad  <= {rn_n[2], rn_n[1], rn_n[0]};
            rm_side.sdist <= rn_side.sdist;
            rm_side.degen <= rn_side.degen;
            rm_len        <= rn_side.len;
        end
    end

    csd_div #(
        .LANES  (HESS_N),
        .NUM_W  (HN_W),
        .QUO_W  (HQ_W),
        .DEN_W  (ROOT_W),
        .SIDE_W (HS_SIDE_W)
    ) u_hess_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rm_vld),
        .i_num   (rm_num),
        .i_den   (rm_len),
        .i_side  (rm_side),
        .o_valid (w_hd_vld),
        .o_quo   (w_hq),
        .o_side  (w_hd_side_raw)
    );

    assign w_hd_side = w_hd_side_raw;

    // Sign and saturate the Hessian quotients
    always_comb begin
        for (int k = 0; k < HESS_N; k++) begin
            if (!w_hd_side.mneg[k]) begin
                if (w_hd_side.ovf[k] || w_hq[k][HQ_W-1]) begin
                    w_h[k] = 32'sh7FFF_FFFF;
                end else begin
                    w_h[k] = $signed(w_hq[k]);
                end
            end else begin
                if (w_hd_side.ovf[k] || (w_hq[k] > 32'h8000_0000)) begin
                    w_h[k] = 32'sh8000_0000;
                end else begin
                    w_h[k] = $signed(~w_hq[k] + 32'd1);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_hd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dist  <= w_hd_side.sdist;
            r_degen <= w_hd_side.degen;
            for (int i = 0; i < 3; i++) begin
                r_grad[i] <= w_hd_side.degen ? 18'sd0 : $signed(w_hd_side.grad[i]);
            end
            for (int k = 0; k < HESS_N; k++) begin
                r_hess[k] <= w_hd_side.degen ? 32'sd0 : w_h[k];
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_distance   = r_dist;
    assign o_grad_x     = r_grad[0];
    assign o_grad_y     = r_grad[1];
    assign o_grad_z     = r_grad[2];
    assign o_hess_xx    = r_hess[0];
    assign o_hess_xy    = r_hess[1];
    assign o_hess_xz    = r_hess[2];
    assign o_hess_yy    = r_hess[3];
    assign o_hess_yz    = r_hess[4];
    assign o_hess_zz    = r_hess[5];
    assign o_degenerate = r_degen;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no item waiting at the output");

    a_degen_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_grad_x == 0 && o_grad_y == 0 && o_grad_z == 0
            && o_hess_xx == 0 && o_hess_xy == 0 && o_hess_xz == 0
            && o_hess_yy == 0 && o_hess_yz == 0 && o_hess_zz == 0))
        else $error("degenerate item carries nonzero gradient or Hessian");

    a_degen_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_distance == (32'sd0 - $signed({1'b0, r_cfg.radius}))))
        else $error("degenerate item distance differs from minus radius");

    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_grad_x <= 18'sd65536 && o_grad_x >= -18'sd65536
            && o_grad_y <= 18'sd65536 && o_grad_y >= -18'sd65536
            && o_grad_z <= 18'sd65536 && o_grad_z >= -18'sd65536))
        else $error("gradient component outside unit range");

endmodule
